// File: rtl/bmr_pkg.sv
// shared types, format codes and sample helpers for the band mean block
package bmr_pkg;

	// sample format codes
	localparam logic [2:0] FMT_S8  = 3'd0;
	localparam logic [2:0] FMT_U8  = 3'd1;
	localparam logic [2:0] FMT_S16 = 3'd2;
	localparam logic [2:0] FMT_U16 = 3'd3;
	localparam logic [2:0] FMT_S32 = 3'd4;
	localparam logic [2:0] FMT_U32 = 3'd5;

	// register indexes
	localparam logic REG_BAND_COUNT    = 1'b0;
	localparam logic REG_SAMPLE_FORMAT = 1'b1;

	// reset values
	localparam logic [4:0] BAND_COUNT_RST    = 5'd1;
	localparam logic [2:0] SAMPLE_FORMAT_RST = FMT_U8;

	localparam int MAX_BANDS_DEF = 16;

	// sign-extended sample width
	localparam int SMP_W = 33;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RND,
		S_MAG,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic acc_add;
		logic close;
		logic rnd;
		logic mag;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic n_one;
	} status_t;

	// codes six and seven behave as u32
	function automatic logic [2:0] fmt_norm(input logic [2:0] code);
		logic [2:0] f;
		f = (code > FMT_U32) ? FMT_U32 : code;
		return f;
	endfunction

	function automatic logic fmt_signed(input logic [2:0] f);
		logic s;
		s = ~f[0];
		return s;
	endfunction

	function automatic logic signed [SMP_W-1:0] fmt_extend(input logic [31:0] raw,
		input logic [2:0] f);
		logic signed [SMP_W-1:0] v;
		unique case (f)
			FMT_S8:  v = {{25{raw[7]}}, raw[7:0]};
			FMT_U8:  v = {25'd0, raw[7:0]};
			FMT_S16: v = {{17{raw[15]}}, raw[15:0]};
			FMT_U16: v = {17'd0, raw[15:0]};
			FMT_S32: v = {raw[31], raw};
			default: v = {1'b0, raw};
		endcase
		return v;
	endfunction

	function automatic logic [31:0] fmt_mask(input logic [31:0] val, input logic [2:0] f);
		logic [31:0] m;
		unique case (f)
			FMT_S8, FMT_U8:   m = {24'd0, val[7:0]};
			FMT_S16, FMT_U16: m = {16'd0, val[15:0]};
			default:          m = val;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/bmr_ctrl.sv
// controller: band counting, handshakes and divide sequencing
module bmr_ctrl #(
	parameter int MAX_BANDS = bmr_pkg::MAX_BANDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_BANDS+1)-1:0]    n_eff,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	output logic                              mean_valid,
	input  logic                              mean_ready,
	input  bmr_pkg::status_t                  status,
	output bmr_pkg::cmd_t                     cmd
);

	localparam int IW     = $clog2(MAX_BANDS);
	localparam int SUM_W  = bmr_pkg::SMP_W + IW;
	localparam int CNTW   = $clog2(SUM_W);

	bmr_pkg::state_t state_q, state_d;
	logic [IW-1:0]   band_idx_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;
	logic            closing;
	logic            accept;
	logic            out_free;
	logic            last_step;

	// pixel ends once taken samples reach the current count
	assign closing = ((IW+1)'(band_idx_q) + (IW+1)'(1)) >= (IW+1)'(n_eff);
	assign sample_ready = ~closing | (state_q == bmr_pkg::S_IDLE);
	assign accept = sample_valid & sample_ready;
	assign out_free = ~out_valid_q | mean_ready;
	assign last_step = (cnt_q == CNTW'(SUM_W - 1));
	assign mean_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmr_pkg::S_IDLE: begin
				if (accept && closing) begin
					state_d = bmr_pkg::S_RND;
				end
			end
			bmr_pkg::S_RND: begin
				state_d = bmr_pkg::S_MAG;
			end
			bmr_pkg::S_MAG: begin
				state_d = status.n_one ? bmr_pkg::S_DONE : bmr_pkg::S_DIV;
			end
			bmr_pkg::S_DIV: begin
				if (last_step) begin
					state_d = bmr_pkg::S_DONE;
				end
			end
			bmr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bmr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.acc_add  = accept;
		cmd.close    = accept & closing;
		cmd.rnd      = (state_q == bmr_pkg::S_RND);
		cmd.mag      = (state_q == bmr_pkg::S_MAG);
		cmd.div_step = (state_q == bmr_pkg::S_DIV);
		cmd.out_load = (state_q == bmr_pkg::S_DONE) & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmr_pkg::S_IDLE;
			band_idx_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				band_idx_q <= closing ? '0 : band_idx_q + IW'(1);
			end
			if (state_q == bmr_pkg::S_DIV) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (mean_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/bmr_dp.sv
// datapath: accumulator, rounding, restoring divider and output register
module bmr_dp #(
	parameter int MAX_BANDS = bmr_pkg::MAX_BANDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_BANDS+1)-1:0]    n_eff,
	input  logic [2:0]                        fmt,
	input  logic [31:0]                       sample,
	input  logic                              line_end,
	input  bmr_pkg::cmd_t                     cmd,
	output bmr_pkg::status_t                  status,
	output logic [31:0]                       mean,
	output logic                              line_last
);

	localparam int NB    = $clog2(MAX_BANDS + 1);
	localparam int IW    = $clog2(MAX_BANDS);
	localparam int SUM_W = bmr_pkg::SMP_W + IW;

	logic signed [SUM_W-1:0] acc_q;
	logic                    end_seen_q;
	logic signed [SUM_W-1:0] cls_sum_q;
	logic [2:0]              cls_fmt_q;
	logic [NB-1:0]           cls_n_q;
	logic                    cls_last_q;
	logic signed [SUM_W:0]   tval_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        quo_q;
	logic [NB-1:0]           rem_q;
	logic [31:0]             mean_q;
	logic                    line_last_q;

	logic signed [SUM_W-1:0] new_sum;
	logic signed [SUM_W:0]   sum_x;
	logic [SUM_W:0]          half_x;
	logic                    sum_pos;
	logic signed [SUM_W:0]   tval;
	logic [SUM_W:0]          mag;
	logic [NB:0]             trial;
	logic                    ge;
	logic [31:0]             q_low;

	assign new_sum = acc_q + SUM_W'(bmr_pkg::fmt_extend(sample, fmt));

	// half-way cases away from zero for signed formats
	assign sum_x   = {cls_sum_q[SUM_W-1], cls_sum_q};
	assign half_x  = (SUM_W+1)'(cls_n_q >> 1);
	assign sum_pos = ~cls_sum_q[SUM_W-1] & (cls_sum_q != '0);
	assign tval    = (bmr_pkg::fmt_signed(cls_fmt_q) && !sum_pos) ?
		sum_x - $signed(half_x) : sum_x + $signed(half_x);

	assign mag = tval_q[SUM_W] ? (~tval_q + (SUM_W+1)'(1)) : tval_q;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, cls_n_q};

	// quotient truncates toward zero
	assign q_low = neg_q ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];

	assign status.n_one = (cls_n_q == NB'(1));
	assign mean         = mean_q;
	assign line_last    = line_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			end_seen_q <= 1'b0;
		end else if (cmd.acc_add) begin
			if (cmd.close) begin
				acc_q      <= '0;
				end_seen_q <= 1'b0;
			end else begin
				acc_q      <= new_sum;
				end_seen_q <= end_seen_q | line_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close) begin
			cls_sum_q  <= new_sum;
			cls_fmt_q  <= fmt;
			cls_n_q    <= n_eff;
			cls_last_q <= end_seen_q | line_end;
		end
		if (cmd.rnd) begin
			tval_q <= tval;
		end
		if (cmd.mag) begin
			neg_q <= tval_q[SUM_W];
			quo_q <= mag[SUM_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? NB'(trial - {1'b0, cls_n_q}) : trial[NB-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
		if (cmd.out_load) begin
			mean_q      <= bmr_pkg::fmt_mask(q_low, cls_fmt_q);
			line_last_q <= cls_last_q;
		end
	end

endmodule

// File: rtl/band_mean_rounded.sv
// band mean with rounding: top level, register port and module wiring
// samples that do not close a pixel are taken one per cycle
// the closing sample of a pixel goes through the rounding, magnitude and bit-serial
// divide states, the divide skipped with one band, before its mean is registered
// one pixel result is in flight at a time: the next closing sample waits for the divider
// asynchronous active-low reset clears the accumulator, band counter and controller
module band_mean_rounded #(
	parameter int MAX_BANDS = bmr_pkg::MAX_BANDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [31:0] sample,
	input  logic        line_end,
	// mean channel
	output logic        mean_valid,
	input  logic        mean_ready,
	output logic [31:0] mean,
	output logic        line_last
);

	localparam int NB = $clog2(MAX_BANDS + 1);
	localparam int CW = (NB > 5) ? NB : 5;

	logic [4:0]        band_count_q;
	logic [2:0]        sample_format_q;
	logic              cfg_wr;
	logic [NB-1:0]     n_eff;
	logic [2:0]        fmt;
	bmr_pkg::cmd_t     cmd;
	bmr_pkg::status_t  status;

	// register write completes in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q    <= bmr_pkg::BAND_COUNT_RST;
			sample_format_q <= bmr_pkg::SAMPLE_FORMAT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bmr_pkg::REG_BAND_COUNT:    band_count_q    <= pwdata[4:0];
				bmr_pkg::REG_SAMPLE_FORMAT: sample_format_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			bmr_pkg::REG_BAND_COUNT:    prdata = {27'd0, band_count_q};
			bmr_pkg::REG_SAMPLE_FORMAT: prdata = {29'd0, sample_format_q};
			default:                    prdata = '0;
		endcase
	end

	// zero bands acts as one, counts above the maximum saturate
	always_comb begin
		if (band_count_q == 5'd0) begin
			n_eff = NB'(1);
		end else if (CW'(band_count_q) > CW'(MAX_BANDS)) begin
			n_eff = NB'(MAX_BANDS);
		end else begin
			n_eff = NB'(band_count_q);
		end
	end

	// unknown format codes act as u32
	assign fmt = bmr_pkg::fmt_norm(sample_format_q);

	bmr_ctrl #(
		.MAX_BANDS(MAX_BANDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.n_eff       (n_eff),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.mean_valid  (mean_valid),
		.mean_ready  (mean_ready),
		.status      (status),
		.cmd         (cmd)
	);

	bmr_dp #(
		.MAX_BANDS(MAX_BANDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_eff    (n_eff),
		.fmt      (fmt),
		.sample   (sample),
		.line_end (line_end),
		.cmd      (cmd),
		.status   (status),
		.mean     (mean),
		.line_last(line_last)
	);

endmodule

// File: dv/tb_band_mean_rounded.sv
// self-checking testbench for band_mean_rounded: directed cases, then random phases
module tb_band_mean_rounded;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 10;
	// bands the block averages at most, the effective count saturates here
	localparam int BAND_LIMIT    = bmr_pkg::MAX_BANDS_DEF;
	// settle wait after the divider at 16 bands, with some margin
	localparam int SETTLE_CYCLES = 48;
	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 1200;

	typedef struct {
		logic [31:0] mean;
		logic        line_last;
	} mean_item_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [31:0] sample       = '0;
	logic        line_end     = 1'b0;
	logic        mean_valid;
	logic        mean_ready   = 1'b0;
	logic [31:0] mean;
	logic        line_last;

	// means predicted but not yet seen on the output, oldest first
	mean_item_t  pending_means[$];
	mean_item_t  oldest_mean;

	// predictor copy of the registers and the per-pixel accumulator
	logic [4:0]  count_reg    = bmr_pkg::BAND_COUNT_RST;
	logic [2:0]  fmt_reg      = bmr_pkg::SAMPLE_FORMAT_RST;
	longint      acc_sum      = 0;
	int          acc_index    = 0;
	logic        acc_end      = 1'b0;

	int          fail_count   = 0;
	int          samples_sent = 0;
	int          idle_cycles  = 0;
	int          ready_hold   = 0;
	// when set, no sender gaps, and no receiver stalls once its current hold ends
	bit          no_idle      = 1'b0;

	band_mean_rounded u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.line_end     (line_end),
		.mean_valid   (mean_valid),
		.mean_ready   (mean_ready),
		.mean         (mean),
		.line_last    (line_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample bits: plain random, or biased toward format extremes
	function automatic logic [31:0] random_sample(input bit extreme);
		int unsigned r;
		r = extreme ? $urandom_range(0, 29) : $urandom_range(0, 99);
		if (r < 10)
			return 32'hFFFF_FFFF;
		if (r < 14)
			return 32'h0;
		if (r < 30) begin
			case ($urandom_range(0, 5))
				0:       return 32'h0000_0080;
				1:       return 32'h0000_8000;
				2:       return 32'h8000_0000;
				3:       return 32'h0000_007F;
				4:       return 32'h0000_7FFF;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	// fold one accepted sample into the predicted accumulator,
	// queue the rounded mean when it closes a pixel
	task automatic fold_sample(input logic [31:0] raw, input logic le);
		logic [2:0]  f;
		longint      n;
		longint      half;
		longint      v;
		longint      q;
		logic [31:0] m;
		mean_item_t  item;
		// codes six and seven act as u32
		f = (fmt_reg > bmr_pkg::FMT_U32) ? bmr_pkg::FMT_U32 : fmt_reg;
		// zero bands means plain copy, large counts saturate
		if (count_reg == 0)
			n = 1;
		else if (count_reg > BAND_LIMIT)
			n = BAND_LIMIT;
		else
			n = count_reg;
		case (f)
			bmr_pkg::FMT_S8:  v = {{56{raw[7]}}, raw[7:0]};
			bmr_pkg::FMT_U8:  v = {56'd0, raw[7:0]};
			bmr_pkg::FMT_S16: v = {{48{raw[15]}}, raw[15:0]};
			bmr_pkg::FMT_U16: v = {48'd0, raw[15:0]};
			bmr_pkg::FMT_S32: v = {{32{raw[31]}}, raw};
			default:          v = {32'd0, raw};
		endcase
		acc_sum = acc_sum + v;
		acc_end = acc_end | le;
		// a lowered count closes the pixel on the next sample
		if (acc_index + 1 < n) begin
			acc_index++;
		end else begin
			half = n / 2;
			// signed formats round half-way away from zero, division truncates
			if ((f == bmr_pkg::FMT_S8 || f == bmr_pkg::FMT_S16 ||
				f == bmr_pkg::FMT_S32) && acc_sum <= 0)
				q = (acc_sum - half) / n;
			else
				q = (acc_sum + half) / n;
			case (f)
				bmr_pkg::FMT_S8, bmr_pkg::FMT_U8:   m = {24'd0, q[7:0]};
				bmr_pkg::FMT_S16, bmr_pkg::FMT_U16: m = {16'd0, q[15:0]};
				default:                            m = q[31:0];
			endcase
			item.mean      = m;
			item.line_last = acc_end;
			pending_means.push_back(item);
			acc_sum   = 0;
			acc_index = 0;
			acc_end   = 1'b0;
		end
	endtask

	// one sample transaction, entered and left at a falling edge
	task automatic send_sample(input logic [31:0] raw, input logic le);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid = 1'b1;
		sample       = raw;
		line_end     = le;
		do
			@(posedge clk);
		while (!sample_ready);
		fold_sample(raw, le);
		samples_sent++;
		@(negedge clk);
	endtask

	// setup cycle, then access cycle; predictor register updates on the write edge
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == bmr_pkg::REG_BAND_COUNT)
			count_reg = value[4:0];
		else
			fmt_reg = value[2:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// hold the sender until every pending mean is out and the divider is quiet
	task automatic settle();
		sample_valid = 1'b0;
		while (pending_means.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register writes only while idle; a partial pixel may stay in the accumulator
	task automatic configure(input logic [4:0] bands, input logic [2:0] fmt);
		settle();
		write_reg(bmr_pkg::REG_BAND_COUNT, {27'd0, bands});
		write_reg(bmr_pkg::REG_SAMPLE_FORMAT, {29'd0, fmt});
	endtask

	// one band: every format code passes its masked sample through
	task automatic test_copy_per_format();
		for (int code = 0; code < 8; code++) begin
			configure(5'd1, code[2:0]);
			send_sample(code[0] ? 32'hFFFF_FFFF : 32'h8000_8080, code[0]);
		end
	endtask

	// a zero count behaves as one band
	task automatic test_zero_band_count();
		configure(5'd0, bmr_pkg::FMT_U16);
		send_sample(32'h1234_ABCD, 1'b0);
	endtask

	// half-way sums: negative rounds down, positive up, unsigned up
	task automatic test_rounding_halfway();
		configure(5'd2, bmr_pkg::FMT_S8);
		send_sample(32'h0000_00FF, 1'b0);
		send_sample(32'h0000_00FE, 1'b1);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'h0000_0002, 1'b0);
		configure(5'd2, bmr_pkg::FMT_U8);
		send_sample(32'h0000_0001, 1'b1);
		send_sample(32'h0000_0002, 1'b0);
	endtask

	// count lowered under the samples already taken: next one closes the pixel
	task automatic test_count_lowered_mid_pixel();
		configure(5'd3, bmr_pkg::FMT_U8);
		send_sample(32'h0000_000A, 1'b1);
		send_sample(32'h0000_0014, 1'b0);
		settle();
		write_reg(bmr_pkg::REG_BAND_COUNT, 32'd1);
		send_sample(32'h0000_001E, 1'b0);
	endtask

	// format switched between two bands of one pixel
	task automatic test_format_changed_mid_pixel();
		configure(5'd2, bmr_pkg::FMT_U8);
		send_sample(32'h0000_00FF, 1'b0);
		settle();
		write_reg(bmr_pkg::REG_SAMPLE_FORMAT, {29'd0, bmr_pkg::FMT_S8});
		send_sample(32'h0000_00FF, 1'b1);
	endtask

	// random phases; the first ones pin widest sums and saturated counts
	task automatic test_random_phases();
		int          phase;
		int          len;
		int          target;
		int unsigned r;
		logic [4:0]  bands;
		logic [2:0]  fmt;
		logic [31:0] raw;
		bit          extreme;
		phase  = 0;
		target = samples_sent + RANDOM_ITEMS;
		while (samples_sent < target) begin
			extreme = ($urandom_range(0, 4) == 0);
			case (phase)
				0: begin
					bands = 5'd16;
					fmt   = bmr_pkg::FMT_U32;
				end
				1: begin
					bands = 5'd31;
					fmt   = bmr_pkg::FMT_S32;
				end
				2: begin
					bands   = 5'd16;
					fmt     = bmr_pkg::FMT_S8;
					extreme = 1'b1;
				end
				3: begin
					bands   = 5'd1;
					fmt     = bmr_pkg::FMT_U32;
					extreme = 1'b1;
				end
				default: begin
					r = $urandom_range(0, 9);
					if (r == 0)
						bands = 5'd0;
					else if (r == 1)
						bands = 5'($urandom_range(17, 31));
					else if (r == 2)
						bands = 5'd16;
					else
						bands = 5'($urandom_range(1, 15));
					if ($urandom_range(0, 9) == 0)
						fmt = 3'($urandom_range(6, 7));
					else
						fmt = 3'($urandom_range(bmr_pkg::FMT_S8, bmr_pkg::FMT_U32));
				end
			endcase
			// some phases run with no gaps, and no stalls once any current hold ends
			no_idle = ($urandom_range(0, 5) == 0);
			configure(bands, fmt);
			len = $urandom_range(10, 60);
			repeat (len) begin
				if (phase == 0)
					raw = 32'hFFFF_FFFF;
				else if (phase == 1)
					raw = 32'h8000_0000;
				else
					raw = random_sample(extreme);
				send_sample(raw, $urandom_range(0, 7) == 0);
			end
			phase++;
		end
		no_idle = 1'b0;
	endtask

	// receiver: ready held for random spans, stalls mostly short
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (no_idle) begin
			mean_ready <= 1'b1;
		end else begin
			mean_ready <= ($urandom_range(0, 2) != 0);
			ready_hold <= pick_gap();
		end
	end

	// every mean transaction is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && mean_valid && mean_ready) begin
			if (pending_means.size() == 0) begin
				$error("mean transaction with none pending: mean %h line_last %b",
					mean, line_last);
				fail_count++;
			end else begin
				oldest_mean = pending_means.pop_front();
				if (mean !== oldest_mean.mean) begin
					$error("mean: expected %h, actual %h", oldest_mean.mean, mean);
					fail_count++;
				end
				if (line_last !== oldest_mean.line_last) begin
					$error("line_last: expected %b, actual %b",
						oldest_mean.line_last, line_last);
					fail_count++;
				end
			end
		end
	end

	// watchdog: any transaction on any port restarts the count
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (mean_valid && mean_ready) ||
			(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_copy_per_format();
		test_zero_band_count();
		test_rounding_halfway();
		test_count_lowered_mid_pixel();
		test_format_changed_mid_pixel();
		test_random_phases();
		// drain the last means and let the divider go quiet
		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
